// ===== rtl/core/cne_pkg.sv =====
// ----------------------------------------------------------------------------
// cne_pkg
// Shared types, character codes and key decode for the number-entry editor.
// ----------------------------------------------------------------------------
package cne_pkg;

  // display geometry
  localparam int TEXT_MAX       = 20;
  localparam int MANTISSA_LIMIT = 12;

  // character codes
  localparam logic [3:0] CH_DOT   = 4'd10;
  localparam logic [3:0] CH_MINUS = 4'd11;
  localparam logic [3:0] CH_BLANK = 4'd12;
  localparam logic [3:0] CH_E     = 4'd13;
  localparam logic [3:0] CH_PLUS  = 4'd14;
  localparam logic [3:0] CH_NONE  = 4'd15;
  localparam logic [3:0] CH_ZERO  = 4'd0;
  localparam logic [3:0] CH_ONE   = 4'd1;

  typedef logic [TEXT_MAX-1:0][3:0] text_t;
  typedef logic [7:0][3:0]          tpl_t;

  // reset text: leading blank, everything else empty
  localparam text_t TEXT_RESET = {{(TEXT_MAX-1){CH_NONE}}, CH_BLANK};

  // exponent template "1.0E+000", element 0 first
  localparam tpl_t UNITY_TPL = {CH_ZERO, CH_ZERO, CH_ZERO, CH_PLUS,
                                CH_E, CH_ZERO, CH_DOT, CH_ONE};

  // entry mode
  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_INT  = 2'd1,
    MODE_FRAC = 2'd2,
    MODE_EXP  = 2'd3
  } mode_t;

  // decoded key action
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_DIGIT,
    ACT_DOT,
    ACT_SIGN,
    ACT_EXP,
    ACT_ENTER,
    ACT_ERASE
  } act_t;

  typedef struct packed {
    act_t       act;
    logic [3:0] digit;
  } key_dec_t;

  // keypad scancode table
  function automatic key_dec_t key_decode(input logic [5:0] code);
    key_dec_t d;
    d.act   = ACT_DIGIT;
    d.digit = 4'd0;
    case (code)
      6'd13:   d.digit = 4'd7;
      6'd14:   d.digit = 4'd4;
      6'd15:   d.digit = 4'd1;
      6'd16:   d.digit = 4'd0;
      6'd17:   d.digit = 4'd8;
      6'd18:   d.digit = 4'd5;
      6'd19:   d.digit = 4'd2;
      6'd21:   d.digit = 4'd9;
      6'd22:   d.digit = 4'd6;
      6'd23:   d.digit = 4'd3;
      6'd20:   d.act   = ACT_DOT;
      6'd24:   d.act   = ACT_SIGN;
      6'd28:   d.act   = ACT_EXP;
      6'd31:   d.act   = ACT_ENTER;
      6'd32:   d.act   = ACT_ERASE;
      default: d.act   = ACT_NONE;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/core/cne_in_if.sv =====
// ----------------------------------------------------------------------------
// cne_in_if
// Key channel: valid/ready handshake with start request, scancode and tag.
// ----------------------------------------------------------------------------
interface cne_in_if;
  logic       valid;
  logic       ready;
  logic       start_req;
  logic [5:0] key;
  logic [7:0] return_tag;

  modport source (output valid, output start_req, output key, output return_tag,
                  input ready);
  modport sink   (input valid, input start_req, input key, input return_tag,
                  output ready);
endinterface

// ===== rtl/core/cne_out_if.sv =====
// ----------------------------------------------------------------------------
// cne_out_if
// Display channel: valid/ready handshake with text, length, mode and return.
// ----------------------------------------------------------------------------
interface cne_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] text_low;
  logic [15:0] text_high;
  logic [4:0]  text_length;
  logic [1:0]  entry_mode;
  logic        returned;
  logic [7:0]  return_value;

  modport source (output valid, output text_low, output text_high,
                  output text_length, output entry_mode, output returned,
                  output return_value, input ready);
  modport sink   (input valid, input text_low, input text_high,
                  input text_length, input entry_mode, input returned,
                  input return_value, output ready);
endinterface

// ===== rtl/core/calculator_number_entry_editor.sv =====
// ----------------------------------------------------------------------------
// calculator_number_entry_editor
// Keypad number-entry editor: one key per transaction edits a 20-char display.
// ----------------------------------------------------------------------------
// The result is valid in the cycle after the key transaction is accepted.
// Throughput: one key per cycle; the edit is a single pass of logic between
// the text registers and the result register, which is the editor state.
// A new key is taken whenever the result register is empty or being read.
// Reset: text " ", length 1, mode idle, stored tag 0, no result pending.
module calculator_number_entry_editor (
  input  logic      clk,
  input  logic      rst,
  cne_in_if.sink    keys,
  cne_out_if.source display
);

  // editor state, which is also the result payload
  cne_pkg::text_t text;
  logic [4:0]     text_len;
  cne_pkg::mode_t mode;
  logic [7:0]     parent_tag;
  logic           returned;
  logic [7:0]     return_value;
  logic           out_valid;

  cne_pkg::text_t text_next;
  logic [4:0]     text_len_next;
  cne_pkg::mode_t mode_next;
  logic [7:0]     parent_tag_next;
  logic           returned_next;

  logic accept;

  assign keys.ready = ~out_valid | display.ready;
  assign accept     = keys.valid & keys.ready;

  // single-pass key edit
  always_comb begin
    cne_pkg::text_t   c;
    cne_pkg::text_t   c_up;
    cne_pkg::text_t   c_dn;
    logic [4:0]       n;
    cne_pkg::mode_t   m;
    logic [7:0]       tag;
    logic             ret;
    cne_pkg::key_dec_t kd;
    logic [3:0]       last;
    logic             special;
    logic             wr_en;
    logic [4:0]       wr_pos;
    logic [3:0]       wr_cnt;
    logic [2:0]       wr_off;
    logic             wr_tpl;
    cne_pkg::tpl_t    wr_str;
    cne_pkg::mode_t   wr_mode;
    logic [5:0]       wr_end;
    logic [2:0]       rel;
    logic             tr_en;
    logic [4:0]       tr_len;
    cne_pkg::mode_t   tr_mode;

    c   = text;
    n   = text_len;
    m   = mode;
    tag = parent_tag;
    ret = 1'b0;

    // restart entry
    if (keys.start_req) begin
      c   = cne_pkg::TEXT_RESET;
      n   = 5'd1;
      m   = cne_pkg::MODE_INT;
      tag = keys.return_tag;
    end

    kd   = cne_pkg::key_decode(keys.key);
    c_up = {cne_pkg::CH_NONE, c[cne_pkg::TEXT_MAX-1:1]};
    c_dn = {c[cne_pkg::TEXT_MAX-2:0], cne_pkg::CH_NONE};
    last = c[n - 5'd1];

    special = (n == 5'd1) ||
              (n == 5'd4 && c[1] == cne_pkg::CH_ZERO && c[2] == cne_pkg::CH_DOT &&
               c[3] == cne_pkg::CH_ZERO) ||
              (n == 5'd3 && c[1] == cne_pkg::CH_ZERO && c[2] == cne_pkg::CH_DOT) ||
              (n == 5'd2 && c[1] == cne_pkg::CH_ZERO);

    wr_en   = 1'b0;
    wr_pos  = n;
    wr_cnt  = 4'd1;
    wr_off  = 3'd0;
    wr_tpl  = 1'b0;
    wr_str  = {8{cne_pkg::CH_NONE}};
    wr_mode = m;
    rel     = 3'd0;
    tr_en   = 1'b0;
    tr_len  = n;
    tr_mode = m;

    if (m != cne_pkg::MODE_IDLE && kd.act != cne_pkg::ACT_NONE) begin
      case (kd.act)
        cne_pkg::ACT_DIGIT: begin
          if (n == 5'd2 && c[1] == cne_pkg::CH_ZERO) begin
            c[1] = kd.digit;
          end else if (m == cne_pkg::MODE_INT &&
                       n > 5'(cne_pkg::MANTISSA_LIMIT)) begin
            // mantissa full
          end else if (m == cne_pkg::MODE_FRAC &&
                       n > 5'(cne_pkg::MANTISSA_LIMIT + 1)) begin
            // mantissa full
          end else if (m == cne_pkg::MODE_EXP) begin
            // shift digit in from the right of the exponent field
            if (n >= 5'd4) begin
              for (int i = 0; i < cne_pkg::TEXT_MAX; i++) begin
                if (5'(i) == n - 5'd1) begin
                  c[i] = kd.digit;
                end else if (5'(i) == n - 5'd2 || 5'(i) == n - 5'd3) begin
                  c[i] = c_up[i];
                end
              end
            end
          end else begin
            wr_en     = 1'b1;
            wr_str[0] = kd.digit;
          end
        end
        cne_pkg::ACT_SIGN: begin
          if (m == cne_pkg::MODE_EXP) begin
            if (n >= 5'd5) begin
              c[n - 5'd4] = (c[n - 5'd4] == cne_pkg::CH_MINUS) ?
                            cne_pkg::CH_PLUS : cne_pkg::CH_MINUS;
            end
          end else begin
            c[0] = (c[0] == cne_pkg::CH_MINUS) ? cne_pkg::CH_BLANK : cne_pkg::CH_MINUS;
          end
        end
        cne_pkg::ACT_DOT: begin
          if (m == cne_pkg::MODE_INT) begin
            wr_en   = 1'b1;
            wr_mode = cne_pkg::MODE_FRAC;
            if (n == 5'd1) begin
              // empty mantissa gets "0."
              wr_pos    = 5'd1;
              wr_cnt    = 4'd2;
              wr_str[0] = cne_pkg::CH_ZERO;
              wr_str[1] = cne_pkg::CH_DOT;
            end else begin
              wr_str[0] = cne_pkg::CH_DOT;
            end
          end
        end
        cne_pkg::ACT_EXP: begin
          if (m == cne_pkg::MODE_EXP) begin
            // drop the exponent field
            if (n >= 5'd6) begin
              tr_en   = 1'b1;
              tr_len  = n - 5'd5;
              tr_mode = cne_pkg::MODE_FRAC;
            end
          end else begin
            wr_en   = 1'b1;
            wr_tpl  = 1'b1;
            wr_mode = cne_pkg::MODE_EXP;
            if (special) begin
              wr_pos = 5'd1;
              wr_cnt = 4'd8;
              wr_off = 3'd0;
            end else if (m == cne_pkg::MODE_INT) begin
              wr_cnt = 4'd7;
              wr_off = 3'd1;
            end else if (last == cne_pkg::CH_DOT) begin
              wr_cnt = 4'd6;
              wr_off = 3'd2;
            end else begin
              wr_cnt = 4'd5;
              wr_off = 3'd3;
            end
          end
        end
        cne_pkg::ACT_ENTER: begin
          m   = cne_pkg::MODE_IDLE;
          ret = 1'b1;
        end
        cne_pkg::ACT_ERASE: begin
          if (m == cne_pkg::MODE_EXP) begin
            // shift exponent digits right, zero in from the left
            if (n >= 5'd4) begin
              for (int i = 0; i < cne_pkg::TEXT_MAX; i++) begin
                if (5'(i) == n - 5'd1 || 5'(i) == n - 5'd2) begin
                  c[i] = c_dn[i];
                end else if (5'(i) == n - 5'd3) begin
                  c[i] = cne_pkg::CH_ZERO;
                end
              end
            end
          end else if (m == cne_pkg::MODE_FRAC && last == cne_pkg::CH_DOT) begin
            tr_en   = 1'b1;
            tr_len  = n - 5'd1;
            tr_mode = cne_pkg::MODE_INT;
          end else if (n > 5'd1) begin
            tr_en  = 1'b1;
            tr_len = n - 5'd1;
          end else begin
            // erase on empty mantissa: show " 0" and hand back
            c[0] = cne_pkg::CH_BLANK;
            c[1] = cne_pkg::CH_ZERO;
            n    = 5'd2;
            m    = cne_pkg::MODE_IDLE;
            ret  = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    // template source for tail writes
    if (wr_tpl) begin
      for (int j = 0; j < 8; j++) begin
        wr_str[j] = cne_pkg::UNITY_TPL[3'(j) + wr_off];
      end
    end

    // tail write, dropped as a whole when it overflows the display
    wr_end = {1'b0, wr_pos} + {2'b00, wr_cnt};
    if (wr_en && wr_end <= 6'(cne_pkg::TEXT_MAX)) begin
      for (int i = 0; i < cne_pkg::TEXT_MAX; i++) begin
        rel = 3'(5'(i) - wr_pos);
        if (5'(i) >= wr_pos) begin
          c[i] = (6'(i) < wr_end) ? wr_str[rel] : cne_pkg::CH_NONE;
        end
      end
      n = wr_end[4:0];
      m = wr_mode;
    end

    // truncation
    if (tr_en) begin
      for (int i = 0; i < cne_pkg::TEXT_MAX; i++) begin
        if (5'(i) >= tr_len) begin
          c[i] = cne_pkg::CH_NONE;
        end
      end
      n = tr_len;
      m = tr_mode;
    end

    text_next       = c;
    text_len_next   = n;
    mode_next       = m;
    parent_tag_next = tag;
    returned_next   = ret;
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      text         <= cne_pkg::TEXT_RESET;
      text_len     <= 5'd1;
      mode         <= cne_pkg::MODE_IDLE;
      parent_tag   <= 8'd0;
      returned     <= 1'b0;
      return_value <= 8'd0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        text         <= text_next;
        text_len     <= text_len_next;
        mode         <= mode_next;
        parent_tag   <= parent_tag_next;
        returned     <= returned_next;
        return_value <= returned_next ? parent_tag_next : 8'd0;
        out_valid    <= 1'b1;
      end else if (display.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result transaction
  assign display.valid        = out_valid;
  assign display.text_low     = text[15:0];
  assign display.text_high    = text[cne_pkg::TEXT_MAX-1:16];
  assign display.text_length  = text_len;
  assign display.entry_mode   = mode;
  assign display.returned     = returned;
  assign display.return_value = return_value;

endmodule
